@@ hw/rtl/sorq_pkg.sv @@
// Shared types and constants for the sorted frame reorder queue.
package sorq_pkg;

  localparam logic       FUNC_ENQUEUE = 1'b0;
  localparam logic       FUNC_DEQUEUE = 1'b1;
  localparam logic [3:0] LIMIT_RESET  = 4'd5;
  localparam logic [7:0] SEQ_WRAP_TOP = 8'd255;
  localparam logic [7:0] SEQ_ZERO     = 8'd0;

  typedef enum logic [1:0] {
    SORQ_HOLD,
    SORQ_INSERT,
    SORQ_SHIFT
  } sorq_op_t;

  typedef struct packed {
    logic [7:0] seq;
    logic [7:0] subseq;
  } sorq_key_t;

  typedef struct packed {
    sorq_op_t op;
    logic     no_sort;
    logic     valid;
    logic     left_valid;
  } sorq_cell_ctl_t;

endpackage

@@ hw/rtl/seq_ordered_frame_reorder_queue.sv @@
// Top level: sorted frame reorder queue built as a chain of entry cells.
// Result: registered on the output register in the cycle after the input transfer.
// Throughput: one operation per cycle unless out_ready is low with a result still held;
//   the compare chain across all cells settles the insert position within that cycle.
// Reset: entry count clears to zero and the limit returns to five; entry
//   contents are not cleared.
module seq_ordered_frame_reorder_queue #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_frame_seq,
  input  logic [7:0]  in_frame_subseq,
  input  logic [15:0] in_frame_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_out_valid,
  output logic [7:0]  out_seq,
  output logic [7:0]  out_subseq,
  output logic [15:0] out_handle,
  output logic        out_dropped,
  output logic [3:0]  out_occupancy,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);
  import sorq_pkg::*;

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [3:0]              limit_r;
  logic                    out_valid_r;
  logic                    res_valid_r;
  logic [7:0]              res_seq_r;
  logic [7:0]              res_subseq_r;
  logic [15:0]             res_handle_r;
  logic                    res_dropped_r;
  logic [3:0]              res_occ_r;

  logic                    accept;
  logic                    is_enq;
  logic                    is_deq;
  logic [CMPW-1:0]         eff_limit;
  logic                    drop;
  logic                    do_insert;
  logic                    do_shift;
  logic                    no_sort;
  sorq_op_t                op;
  sorq_key_t               new_key;
  logic [HANDLE_WIDTH-1:0] new_handle;

  sorq_key_t               key_q    [QUEUE_DEPTH];
  logic [HANDLE_WIDTH-1:0] handle_q [QUEUE_DEPTH];
  logic                    found    [QUEUE_DEPTH+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_enq   = (in_func == FUNC_ENQUEUE);
  assign is_deq   = (in_func == FUNC_DEQUEUE);

  assign eff_limit = (CMPW'(limit_r) > CMPW'(QUEUE_DEPTH)) ? CMPW'(QUEUE_DEPTH)
                                                          : CMPW'(limit_r);
  assign drop      = CMPW'(count_r) >= eff_limit;
  assign do_insert = accept && is_enq && !drop;
  assign do_shift  = accept && is_deq && (count_r > CW'(1));
  assign no_sort   = (in_frame_seq == SEQ_ZERO) && (count_r != '0) &&
                     (key_q[0].seq == SEQ_WRAP_TOP);

  always_comb begin
    if (do_insert) begin
      op = SORQ_INSERT;
    end else if (do_shift) begin
      op = SORQ_SHIFT;
    end else begin
      op = SORQ_HOLD;
    end
  end

  assign new_key.seq    = in_frame_seq;
  assign new_key.subseq = in_frame_subseq;
  assign new_handle     = HANDLE_WIDTH'(in_frame_handle);
  assign found[0]       = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sorq_cell_ctl_t          ctl;
    sorq_key_t               left_key;
    logic [HANDLE_WIDTH-1:0] left_handle;
    sorq_key_t               right_key;
    logic [HANDLE_WIDTH-1:0] right_handle;

    assign ctl.op         = op;
    assign ctl.no_sort    = no_sort;
    assign ctl.valid      = count_r > CW'(i);
    assign ctl.left_valid = count_r >= CW'(i);

    if (i == 0) begin : g_first
      assign left_key    = new_key;
      assign left_handle = new_handle;
    end else begin : g_mid
      assign left_key    = key_q[i-1];
      assign left_handle = handle_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_key    = key_q[i];
      assign right_handle = handle_q[i];
    end else begin : g_inner
      assign right_key    = key_q[i+1];
      assign right_handle = handle_q[i+1];
    end

    sorq_cell #(
      .HANDLE_WIDTH(HANDLE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_key     (new_key),
      .new_handle  (new_handle),
      .left_key    (left_key),
      .left_handle (left_handle),
      .right_key   (right_key),
      .right_handle(right_handle),
      .found_in    (found[i]),
      .found_out   (found[i+1]),
      .key_q       (key_q[i]),
      .handle_q    (handle_q[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (do_shift) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_valid_r   <= is_deq && (count_r != '0);
      res_dropped_r <= is_enq && drop;
      res_occ_r     <= 4'(count_nxt);
      if (is_deq && (count_r != '0)) begin
        res_seq_r    <= key_q[0].seq;
        res_subseq_r <= key_q[0].subseq;
        res_handle_r <= 16'(handle_q[0]);
      end else begin
        res_seq_r    <= '0;
        res_subseq_r <= '0;
        res_handle_r <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_out_valid = res_valid_r;
  assign out_seq       = res_seq_r;
  assign out_subseq    = res_subseq_r;
  assign out_handle    = res_handle_r;
  assign out_dropped   = res_dropped_r;
  assign out_occupancy = res_occ_r;

endmodule

@@ hw/rtl/sorq_cell.sv @@
// One entry cell of the sorted queue chain: compare, insert and shift.
module sorq_cell #(
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                      clk,
  input  sorq_pkg::sorq_cell_ctl_t  ctl,
  input  sorq_pkg::sorq_key_t       new_key,
  input  logic [HANDLE_WIDTH-1:0]   new_handle,
  input  sorq_pkg::sorq_key_t       left_key,
  input  logic [HANDLE_WIDTH-1:0]   left_handle,
  input  sorq_pkg::sorq_key_t       right_key,
  input  logic [HANDLE_WIDTH-1:0]   right_handle,
  input  logic                      found_in,
  output logic                      found_out,
  output sorq_pkg::sorq_key_t       key_q,
  output logic [HANDLE_WIDTH-1:0]   handle_q
);
  import sorq_pkg::*;

  sorq_key_t               key_r;
  sorq_key_t               key_nxt;
  logic [HANDLE_WIDTH-1:0] handle_r;
  logic [HANDLE_WIDTH-1:0] handle_nxt;
  logic                    gt;
  logic                    take_new;
  logic                    take_left;

  assign gt = ctl.valid && !ctl.no_sort &&
              ((key_r.seq > new_key.seq) ||
               ((key_r.seq == new_key.seq) && (key_r.subseq > new_key.subseq)));
  assign found_out = found_in || gt;
  assign take_new  = !found_in && (gt || (!ctl.valid && ctl.left_valid));
  assign take_left = found_in && ctl.left_valid;

  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    unique case (ctl.op)
      SORQ_INSERT: begin
        if (take_new) begin
          key_nxt    = new_key;
          handle_nxt = new_handle;
        end else if (take_left) begin
          key_nxt    = left_key;
          handle_nxt = left_handle;
        end
      end
      SORQ_SHIFT: begin
        key_nxt    = right_key;
        handle_nxt = right_handle;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

  assign key_q    = key_r;
  assign handle_q = handle_r;

endmodule
